// File: design/sktab_pkg.sv
// ----------------------------------------------------------------------------
// sktab_pkg
// Shared types, constants and helper functions of the sorted key table.
// ----------------------------------------------------------------------------
package sktab_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 20;
	localparam int PAYLOAD_W    = 32;
	localparam int NODE_W       = PAYLOAD_W + 1;
	localparam int TREE_FANIN   = 8;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_DUP     = 2'd2,
		STATUS_MISSING = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic ins_en;
		logic occupied;
	} cell_ctrl_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

	function automatic int tree_levels(input int cap);
		int n;
		int lv;
		n  = 1;
		lv = 0;
		for (int i = 0; i < 16; i++) begin
			if (n < cap) begin
				n  = n * TREE_FANIN;
				lv = lv + 1;
			end
		end
		return lv;
	endfunction

	function automatic int level_nodes(input int levels, input int lvl);
		int n;
		n = 1;
		for (int i = 0; i < 16; i++) begin
			if (i < levels - lvl) begin
				n = n * TREE_FANIN;
			end
		end
		return n;
	endfunction

	function automatic int node_base(input int levels, input int lvl);
		int base;
		base = 0;
		for (int m = 1; m < 16; m++) begin
			if (m < lvl) begin
				base = base + level_nodes(levels, m);
			end
		end
		return base;
	endfunction

endpackage

// File: design/sktab_cell.sv
// ----------------------------------------------------------------------------
// sktab_cell
// One table slot: holds a key and payload, compares against the request key
// and takes the new entry or the lower neighbor's entry on an insert.
// ----------------------------------------------------------------------------
module sktab_cell (
	input  logic                           clk,
	input  sktab_pkg::cell_ctrl_t          ctrl,
	input  logic [sktab_pkg::KEY_W-1:0]     new_key,
	input  logic [sktab_pkg::PAYLOAD_W-1:0] new_payload,
	input  logic [sktab_pkg::KEY_W-1:0]     prev_key,
	input  logic [sktab_pkg::PAYLOAD_W-1:0] prev_payload,
	input  logic                           prev_lt,
	output logic [sktab_pkg::KEY_W-1:0]     key,
	output logic [sktab_pkg::PAYLOAD_W-1:0] payload,
	output sktab_pkg::cell_flags_t         flags
);

	logic [sktab_pkg::KEY_W-1:0]     key_q;
	logic [sktab_pkg::PAYLOAD_W-1:0] payload_q;

	always_comb begin
		flags.lt = ctrl.occupied && (key_q < new_key);
		flags.eq = ctrl.occupied && (key_q == new_key);
	end

	// hold below the insert point, place the new entry at it, shift above it
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && !flags.lt) begin
			if (prev_lt) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end else begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end
		end
	end

	assign key     = key_q;
	assign payload = payload_q;

endmodule

// File: design/sktab_or_tree.sv
// ----------------------------------------------------------------------------
// sktab_or_tree
// Registered OR tree that gathers the single matching cell's payload and a
// hit flag from all cells, one tree level per cycle.
// ----------------------------------------------------------------------------
module sktab_or_tree #(
	parameter int CAPACITY = sktab_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic [CAPACITY-1:0]            hit,
	input  logic [sktab_pkg::PAYLOAD_W-1:0] data [CAPACITY],
	output logic                           root_hit,
	output logic [sktab_pkg::PAYLOAD_W-1:0] root_data
);

	localparam int F      = sktab_pkg::TREE_FANIN;
	localparam int LEVELS = sktab_pkg::tree_levels(CAPACITY);
	localparam int LEAVES = sktab_pkg::level_nodes(LEVELS, 0);
	localparam int NODES  = sktab_pkg::node_base(LEVELS, LEVELS + 1);
	localparam int ROOT   = sktab_pkg::node_base(LEVELS, LEVELS);

	logic [sktab_pkg::NODE_W-1:0] leaf [LEAVES];
	logic [sktab_pkg::NODE_W-1:0] node_q [NODES];

	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < CAPACITY) begin : g_used
			assign leaf[i] = hit[i] ? {1'b1, data[i]} : '0;
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		localparam int BASE      = sktab_pkg::node_base(LEVELS, l);
		localparam int PREV_BASE = sktab_pkg::node_base(LEVELS, l - 1);
		for (genvar j = 0; j < sktab_pkg::level_nodes(LEVELS, l); j++) begin : g_node
			logic [sktab_pkg::NODE_W-1:0] merged;
			if (l == 1) begin : g_from_leaf
				always_comb begin
					merged = '0;
					for (int c = 0; c < F; c++) begin
						merged = merged | leaf[j * F + c];
					end
				end
			end else begin : g_from_node
				always_comb begin
					merged = '0;
					for (int c = 0; c < F; c++) begin
						merged = merged | node_q[PREV_BASE + j * F + c];
					end
				end
			end
			always_ff @(posedge clk) begin
				node_q[BASE + j] <= merged;
			end
		end
	end

	assign root_hit  = node_q[ROOT][sktab_pkg::PAYLOAD_W];
	assign root_data = node_q[ROOT][sktab_pkg::PAYLOAD_W-1:0];

endmodule

// File: design/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Sorted key/payload table: ordered insert with full and duplicate checks,
// and exact-match lookup.
// ----------------------------------------------------------------------------
// One request is in flight at a time: a request transfers in idle, the
// search state then waits while the registered OR tree collects the match
// flag and payload from the row of slot cells, and the commit state writes
// the result once the output register is free. A new request can transfer
// only after the commit, when control is back in idle. The compare and the
// insert shift happen in all cells at once. The result sits in an output
// register, so the next request transfers while a result still waits to be
// taken. There is no clearing pass after reset.
module sorted_key_table_top #(
	parameter int CAPACITY = sktab_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           command,
	input  logic [sktab_pkg::KEY_W-1:0]     key,
	input  logic [sktab_pkg::PAYLOAD_W-1:0] payload,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [1:0]                     status,
	output logic [sktab_pkg::PAYLOAD_W-1:0] found_payload
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int LEVELS = sktab_pkg::tree_levels(CAPACITY);
	localparam int LVL_W  = $clog2(LEVELS + 1);

	sktab_pkg::state_t state_q, state_n;
	logic [LVL_W-1:0]  lvl_cnt_q;
	logic [CNT_W-1:0]  count_q;

	sktab_pkg::cmd_t                 req_cmd_q;
	logic [sktab_pkg::KEY_W-1:0]     req_key_q;
	logic [sktab_pkg::PAYLOAD_W-1:0] req_payload_q;

	logic                            rsp_valid_q;
	sktab_pkg::status_t              status_q;
	logic [sktab_pkg::PAYLOAD_W-1:0] found_payload_q;

	logic [sktab_pkg::KEY_W-1:0]     cell_key [CAPACITY];
	logic [sktab_pkg::PAYLOAD_W-1:0] cell_payload [CAPACITY];
	logic [CAPACITY-1:0]             lt_vec;
	logic [CAPACITY-1:0]             eq_vec;

	logic                            root_hit;
	logic [sktab_pkg::PAYLOAD_W-1:0] root_data;

	logic                            req_xfer;
	logic                            commit_load;
	logic                            full;
	logic                            ins_ok;
	sktab_pkg::status_t              status_n;
	logic [sktab_pkg::PAYLOAD_W-1:0] found_payload_n;

	assign req_xfer = req_valid && req_ready;
	assign full     = count_q >= CNT_W'(CAPACITY);

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sktab_pkg::cell_ctrl_t  ctrl;
		sktab_pkg::cell_flags_t flags;
		logic [sktab_pkg::KEY_W-1:0]     prev_key;
		logic [sktab_pkg::PAYLOAD_W-1:0] prev_payload;
		logic                            prev_lt;

		assign ctrl.ins_en   = ins_ok && commit_load;
		assign ctrl.occupied = count_q > CNT_W'(i);

		if (i == 0) begin : g_first
			assign prev_key     = req_key_q;
			assign prev_payload = req_payload_q;
			assign prev_lt      = 1'b1;
		end else begin : g_rest
			assign prev_key     = cell_key[i-1];
			assign prev_payload = cell_payload[i-1];
			assign prev_lt      = lt_vec[i-1];
		end

		sktab_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.new_key      (req_key_q),
			.new_payload  (req_payload_q),
			.prev_key     (prev_key),
			.prev_payload (prev_payload),
			.prev_lt      (prev_lt),
			.key          (cell_key[i]),
			.payload      (cell_payload[i]),
			.flags        (flags)
		);

		assign lt_vec[i] = flags.lt;
		assign eq_vec[i] = flags.eq;
	end

	sktab_or_tree #(
		.CAPACITY (CAPACITY)
	) u_tree (
		.clk       (clk),
		.hit       (eq_vec),
		.data      (cell_payload),
		.root_hit  (root_hit),
		.root_data (root_data)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			sktab_pkg::ST_IDLE: begin
				if (req_valid) state_n = sktab_pkg::ST_SEARCH;
			end
			sktab_pkg::ST_SEARCH: begin
				if (lvl_cnt_q == LVL_W'(LEVELS - 1)) state_n = sktab_pkg::ST_COMMIT;
			end
			sktab_pkg::ST_COMMIT: begin
				if (commit_load) state_n = sktab_pkg::ST_IDLE;
			end
			default: state_n = sktab_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready       = state_q == sktab_pkg::ST_IDLE;
		commit_load     = (state_q == sktab_pkg::ST_COMMIT) && (!rsp_valid_q || rsp_ready);
		ins_ok          = (req_cmd_q == sktab_pkg::CMD_INSERT) && !full && !root_hit;
		found_payload_n = '0;
		if (req_cmd_q == sktab_pkg::CMD_INSERT) begin
			if (full) status_n = sktab_pkg::STATUS_FULL;
			else if (root_hit) status_n = sktab_pkg::STATUS_DUP;
			else status_n = sktab_pkg::STATUS_OK;
		end else begin
			if (root_hit) begin
				status_n        = sktab_pkg::STATUS_OK;
				found_payload_n = root_data;
			end else begin
				status_n = sktab_pkg::STATUS_MISSING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sktab_pkg::ST_IDLE;
			lvl_cnt_q   <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == sktab_pkg::ST_SEARCH) lvl_cnt_q <= lvl_cnt_q + LVL_W'(1);
			else lvl_cnt_q <= '0;
			if (commit_load && ins_ok) count_q <= count_q + CNT_W'(1);
			if (commit_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_cmd_q     <= sktab_pkg::cmd_t'(command);
			req_key_q     <= key;
			req_payload_q <= payload;
		end
		if (commit_load) begin
			status_q        <= status_n;
			found_payload_q <= found_payload_n;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign found_payload = found_payload_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit_load && ins_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("entry count did not advance on insert");

	a_count_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == sktab_pkg::ST_COMMIT))
		else $error("entry count changed outside commit");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_vec))
		else $error("key held by more than one slot");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		((lt_vec >> 1) & ~lt_vec) == '0)
		else $error("slots out of order");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_key_table_top. A directed table covers the
// empty table, the key extremes and duplicate inserts. A long random run then
// fills the table to capacity and keeps probing it with hits, near misses,
// duplicates and inserts into the full table. Each request transfer is
// predicted by a local sorted-table model, or taken from its directed row where
// the row is typed, and each response transfer is compared in order. Both channels
// idle and stall in phases, with a long response hold-off and two full drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int TABLE_CAP   = sktab_pkg::CAPACITY_DEF;
	localparam int KEY_W       = sktab_pkg::KEY_W;
	localparam int PAYLOAD_W   = sktab_pkg::PAYLOAD_W;
	localparam int RAND_ITEMS  = 1950;
	localparam int CHUNK       = 130;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 8;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		sktab_pkg::status_t     st;
		logic [PAYLOAD_W-1:0]   fp;
	} table_rsp_t;

	typedef struct packed {
		sktab_pkg::cmd_t        cmd;
		logic [KEY_W-1:0]       k;
		logic [PAYLOAD_W-1:0]   p;
		logic                   typed;
		sktab_pkg::status_t     st;
		logic [PAYLOAD_W-1:0]   fp;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [0:19] = '{
		'{sktab_pkg::CMD_LOOKUP, 20'h00000, 32'h0000_0000, 1'b1, sktab_pkg::STATUS_MISSING, 32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1, sktab_pkg::STATUS_MISSING, 32'h0},
		'{sktab_pkg::CMD_INSERT, 20'h80000, 32'hFFFF_FFFF, 1'b1, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_INSERT, 20'h00000, 32'h0000_0000, 1'b1, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_INSERT, 20'hFFFFF, 32'hA5A5_A5A5, 1'b1, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_INSERT, 20'h80000, 32'h1234_5678, 1'b1, sktab_pkg::STATUS_DUP,     32'h0},
		'{sktab_pkg::CMD_INSERT, 20'h00000, 32'hFFFF_FFFF, 1'b1, sktab_pkg::STATUS_DUP,     32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'h80000, 32'h5555_5555, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'h00000, 32'h0000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'hFFFFF, 32'h0000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'h7FFFF, 32'h0000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_INSERT, 20'h40000, 32'h5A5A_5A5A, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_INSERT, 20'h00001, 32'h0000_0001, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_INSERT, 20'hFFFFE, 32'hFFFF_FFFE, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_INSERT, 20'h7FFFF, 32'h8000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'h40000, 32'hAAAA_AAAA, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'h00001, 32'h0000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'hFFFFE, 32'h0000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'h7FFFF, 32'h0000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0},
		'{sktab_pkg::CMD_LOOKUP, 20'h00002, 32'h0000_0000, 1'b0, sktab_pkg::STATUS_OK,      32'h0}
	};

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 req_valid     = 1'b0;
	logic                 req_ready;
	logic                 command       = 1'b0;
	logic [KEY_W-1:0]     key           = '0;
	logic [PAYLOAD_W-1:0] payload       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready     = 1'b0;
	logic [1:0]           status;
	logic [PAYLOAD_W-1:0] found_payload;

	logic                 cur_typed     = 1'b0;
	sktab_pkg::status_t   cur_st        = sktab_pkg::STATUS_OK;
	logic [PAYLOAD_W-1:0] cur_fp        = '0;

	logic [KEY_W-1:0]     tbl_keys [TABLE_CAP];
	logic [PAYLOAD_W-1:0] tbl_pays [TABLE_CAP];
	int                   tbl_count     = 0;
	table_rsp_t           pending_rsp [$];
	int                   mismatch_cnt  = 0;

	int                   send_pct      = 0;
	int                   recv_pct      = 0;
	int                   hold_id       = 0;
	int                   hold_seen     = 0;
	int                   hold_left     = 0;

	sorted_key_table_top #(
		.CAPACITY(TABLE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.command(command),
		.key(key),
		.payload(payload),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.found_payload(found_payload)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("sorted_key_table_top test failed");
		$finish;
	end

	function automatic table_rsp_t table_step(input sktab_pkg::cmd_t c,
			input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] p);
		table_rsp_t r;
		int pos;
		int i;
		r.st = sktab_pkg::STATUS_OK;
		r.fp = '0;
		pos = 0;
		while (pos < tbl_count && tbl_keys[pos] < k)
			pos++;
		if (c == sktab_pkg::CMD_INSERT) begin
			if (tbl_count >= TABLE_CAP) begin
				r.st = sktab_pkg::STATUS_FULL;
			end else if (pos < tbl_count && tbl_keys[pos] == k) begin
				r.st = sktab_pkg::STATUS_DUP;
			end else begin
				for (i = tbl_count; i > pos; i--) begin
					tbl_keys[i] = tbl_keys[i-1];
					tbl_pays[i] = tbl_pays[i-1];
				end
				tbl_keys[pos] = k;
				tbl_pays[pos] = p;
				tbl_count++;
			end
		end else if (pos < tbl_count && tbl_keys[pos] == k) begin
			r.fp = tbl_pays[pos];
		end else begin
			r.st = sktab_pkg::STATUS_MISSING;
		end
		return r;
	endfunction

	// predict on every request transfer
	always @(posedge clk) begin
		table_rsp_t r;
		if (arst_n && req_valid && req_ready) begin
			r = table_step(sktab_pkg::cmd_t'(command), key, payload);
			if (cur_typed) begin
				r.st = cur_st;
				r.fp = cur_fp;
			end
			pending_rsp.push_back(r);
		end
	end

	// check response transfers, then pick the next ready
	always @(posedge clk) begin
		table_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response status %0d payload %h", $time,
					status, found_payload);
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					mismatch_cnt++;
				end
				if (found_payload !== want.fp) begin
					$display("%0t: found_payload expected %h actual %h", $time, want.fp,
						found_payload);
					mismatch_cnt++;
				end
			end
		end
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_id != hold_seen) begin
			hold_seen = hold_id;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	task automatic send_item(input sktab_pkg::cmd_t c, input logic [KEY_W-1:0] k,
			input logic [PAYLOAD_W-1:0] p, input logic typed, input sktab_pkg::status_t st,
			input logic [PAYLOAD_W-1:0] fp);
		while (send_pct > 0 && $urandom_range(99) < send_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command   <= c;
		key       <= k;
		payload   <= p;
		cur_typed <= typed;
		cur_st    <= st;
		cur_fp    <= fp;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic drain_all();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp.size() != 0);
	endtask

	initial begin
		sktab_pkg::cmd_t      c;
		logic [KEY_W-1:0]     k;
		logic [PAYLOAD_W-1:0] p;
		int                   roll;
		int                   idx;
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int r = 0; r < 20; r++)
			send_item(DIR_ROWS[r].cmd, DIR_ROWS[r].k, DIR_ROWS[r].p, DIR_ROWS[r].typed,
				DIR_ROWS[r].st, DIR_ROWS[r].fp);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % CHUNK == 0) begin
				case (idle_mode_t'((n / CHUNK) % 4))
					IDLE_NONE: begin
						send_pct = 0;
						recv_pct <= 0;
					end
					IDLE_SEND: begin
						send_pct = 86;
						recv_pct <= 0;
					end
					IDLE_RECV: begin
						send_pct = 0;
						recv_pct <= 86;
					end
					default: begin
						send_pct = 27;
						recv_pct <= 27;
					end
				endcase
			end
			// hold the response side while the request side keeps offering requests
			if (n == 40)
				hold_id <= hold_id + 1;
			if (n == 700 || n == 1500)
				drain_all();
			c = ($urandom_range(7) == 0) ? sktab_pkg::CMD_INSERT : sktab_pkg::CMD_LOOKUP;
			p = $urandom();
			roll = $urandom_range(99);
			idx = (tbl_count > 0) ? $urandom_range(tbl_count - 1) : 0;
			if (tbl_count > 0 && roll < ((c == sktab_pkg::CMD_INSERT) ? 33 : 55))
				k = tbl_keys[idx];
			else if (tbl_count > 0 && roll < 70)
				k = tbl_keys[idx] + (roll[0] ? 20'h00001 : 20'hFFFFF);
			else if (roll < 80)
				k = roll[0] ? '1 : '0;
			else
				k = KEY_W'($urandom());
			send_item(c, k, p, 1'b0, sktab_pkg::STATUS_OK, '0);
		end
		send_pct = 0;
		recv_pct <= 0;
		drain_all();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("sorted_key_table_top test passed");
		end else begin
			$display("sorted_key_table_top test failed");
		end
		$finish;
	end

endmodule
